// ===== sv/cra_pkg.sv =====
package cra_pkg;

  // The body index port is eight bits wide, so at most this many entries are reachable.
  localparam int MaxBodies = 256;

  // Lanes of one body entry: force x, y, z, then torque x, y, z.
  localparam int NumLanes  = 6;
  localparam int LaneForceX  = 0;
  localparam int LaneForceY  = 1;
  localparam int LaneForceZ  = 2;
  localparam int LaneTorqueX = 3;
  localparam int LaneTorqueY = 4;
  localparam int LaneTorqueZ = 5;

  typedef logic [31:0] word_t;
  typedef word_t [NumLanes-1:0] entry_t;

  typedef enum logic {
    REQ_ACCUM = 1'b0,
    REQ_READ  = 1'b1
  } req_e;

  // On the first constraint side, body zero stands for "no body".
  localparam logic SideFirst = 1'b0;

endpackage

// ===== sv/constraint_reaction_accumulator_top.sv =====
// A read item shows its result on done_o after stage one, stage two and the result register.
// A new item is held off by busy_o while the previous one is in stage one of the body memory
// read-modify-write (read, multiply, saturating add and write back, with forwarding of the pending write).
// Reset is asynchronous and active low; it clears one valid bit per entry at once, so an
// entry that was never written reads as zero and no clearing pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle.
module constraint_reaction_accumulator_top #(
  parameter int NUM_BODIES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               req_type_i,
  input  logic [7:0]         body_index_i,
  input  logic               side_i,
  input  logic signed [31:0] multiplier_i,
  input  logic signed [31:0] lin_factor_x_i,
  input  logic signed [31:0] lin_factor_y_i,
  input  logic signed [31:0] lin_factor_z_i,
  input  logic signed [31:0] rot_factor_x_i,
  input  logic signed [31:0] rot_factor_y_i,
  input  logic signed [31:0] rot_factor_z_i,
  output logic               done_o,
  output logic signed [31:0] force_x_o,
  output logic signed [31:0] force_y_o,
  output logic signed [31:0] force_z_o,
  output logic signed [31:0] torque_x_o,
  output logic signed [31:0] torque_y_o,
  output logic signed [31:0] torque_z_o
);

  localparam int Depth = (NUM_BODIES < cra_pkg::MaxBodies) ? NUM_BODIES : cra_pkg::MaxBodies;
  localparam int AddrW = $clog2(Depth);

  // Floor of the Q16.16 product, saturated to 32 bits.
  function automatic logic [31:0] sat_prod(input logic signed [63:0] p);
    logic fits;
    fits = (&p[63:47]) || !(|p[63:47]);
    if (fits) begin
      return p[47:16];
    end else if (p[63]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7fff_ffff;
    end
  endfunction

  // Saturating 32-bit signed add.
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      return s[31:0];
    end
  endfunction

  logic                 accept;
  logic [AddrW-1:0]     addr_in;
  logic                 in_range;
  logic                 skip_side;
  cra_pkg::entry_t      fac_in;

  logic                 s1_q, s2_q;
  logic                 done_q;

  cra_pkg::entry_t      mem_q [Depth];
  logic [Depth-1:0]     vld_q;

  cra_pkg::entry_t      rd_q;
  logic                 rd_vld_q;
  logic                 byp_q;
  cra_pkg::entry_t      byp_data_q;
  logic [AddrW-1:0]     addr1_q, addr2_q;
  logic                 read1_q, read2_q;
  logic                 we1_q, we2_q;
  logic                 range1_q, range2_q;
  logic signed [31:0]   mult1_q;
  cra_pkg::entry_t      fac1_q;

  cra_pkg::entry_t      old1;
  cra_pkg::entry_t      old2_q;
  logic signed [63:0]   prod2_q [cra_pkg::NumLanes];

  cra_pkg::entry_t      sum2;
  cra_pkg::entry_t      wr_data;
  logic                 wr_en;
  cra_pkg::entry_t      out_q;

  // Input decode.
  assign accept    = start_i && !busy_o;
  assign addr_in   = body_index_i[AddrW-1:0];
  assign in_range  = {24'd0, body_index_i} < 32'(NUM_BODIES);
  assign skip_side = (side_i == cra_pkg::SideFirst) && (body_index_i == 8'd0);

  assign fac_in[cra_pkg::LaneForceX]  = lin_factor_x_i;
  assign fac_in[cra_pkg::LaneForceY]  = lin_factor_y_i;
  assign fac_in[cra_pkg::LaneForceZ]  = lin_factor_z_i;
  assign fac_in[cra_pkg::LaneTorqueX] = rot_factor_x_i;
  assign fac_in[cra_pkg::LaneTorqueY] = rot_factor_y_i;
  assign fac_in[cra_pkg::LaneTorqueZ] = rot_factor_z_i;

  // A new item may enter while the previous one is writing back.
  assign busy_o = s1_q;

  // Stage control and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= accept;
      s2_q   <= s1_q;
      done_q <= s2_q && read2_q;
    end
  end

  // Entry valid bits; an entry never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[addr2_q] <= 1'b1;
    end
  end

  // Body memory: registered read at the start transfer, write back at the end of stage two.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr2_q] <= wr_data;
    end
    if (accept) begin
      rd_q     <= mem_q[addr_in];
      rd_vld_q <= vld_q[addr_in];
    end
  end

  // Capture the item, and forward a write that lands on the same body in this cycle.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byp_q      <= wr_en && (addr2_q == addr_in);
      byp_data_q <= wr_data;
      addr1_q    <= addr_in;
      read1_q    <= (req_type_i == cra_pkg::REQ_READ);
      we1_q      <= in_range && ((req_type_i == cra_pkg::REQ_READ) || !skip_side);
      range1_q   <= in_range;
      mult1_q    <= multiplier_i;
      fac1_q     <= fac_in;
    end
  end

  // Stage one: pick the current entry value and form the six products.
  assign old1 = byp_q ? byp_data_q : (rd_vld_q ? rd_q : '0);

  always_ff @(posedge clk_i) begin
    if (s1_q) begin
      old2_q   <= old1;
      addr2_q  <= addr1_q;
      read2_q  <= read1_q;
      we2_q    <= we1_q;
      range2_q <= range1_q;
      for (int k = 0; k < cra_pkg::NumLanes; k++) begin
        prod2_q[k] <= 64'(mult1_q) * 64'($signed(fac1_q[k]));
      end
    end
  end

  // Stage two: scale, saturate and add; a read clears the entry.
  always_comb begin
    for (int k = 0; k < cra_pkg::NumLanes; k++) begin
      sum2[k] = sat_add(old2_q[k], sat_prod(prod2_q[k]));
    end
  end

  assign wr_data = read2_q ? '0 : sum2;
  assign wr_en   = s2_q && we2_q;

  // Result register; a body out of range reads as zero.
  always_ff @(posedge clk_i) begin
    if (s2_q && read2_q) begin
      out_q <= range2_q ? old2_q : '0;
    end
  end

  assign done_o     = done_q;
  assign force_x_o  = out_q[cra_pkg::LaneForceX];
  assign force_y_o  = out_q[cra_pkg::LaneForceY];
  assign force_z_o  = out_q[cra_pkg::LaneForceZ];
  assign torque_x_o = out_q[cra_pkg::LaneTorqueX];
  assign torque_y_o = out_q[cra_pkg::LaneTorqueY];
  assign torque_z_o = out_q[cra_pkg::LaneTorqueZ];

endmodule

// ===== sv/cra_checker.sv =====
module cra_checker #(
  parameter int NUM_BODIES = 256
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               req_type_i,
  input logic [7:0]         body_index_i,
  input logic               done_o,
  input logic signed [31:0] force_x_o,
  input logic signed [31:0] force_y_o,
  input logic signed [31:0] force_z_o,
  input logic signed [31:0] torque_x_o,
  input logic signed [31:0] torque_y_o,
  input logic signed [31:0] torque_z_o
);

  logic acc_read;
  logic acc_read_far;

  assign acc_read     = start_i && !busy_o && (req_type_i == cra_pkg::REQ_READ);
  assign acc_read_far = acc_read && ({24'd0, body_index_i} >= 32'(NUM_BODIES));

  // A start transfer makes the block busy for exactly one cycle.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy_o did not rise after a start transfer");

  a_busy_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> !busy_o)
    else $error("busy_o held for more than one cycle");

  // Every result strobe belongs to an earlier read transfer.
  a_done_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc_read, 3))
    else $error("result strobe without a matching read transfer");

  // A read transfer always produces its result strobe.
  a_read_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_read |-> ##3 done_o)
    else $error("read transfer produced no result");

  // A body beyond the table reads as all zero.
  a_far_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(acc_read_far, 3)) |->
      (force_x_o == 32'sd0 && force_y_o == 32'sd0 && force_z_o == 32'sd0 &&
       torque_x_o == 32'sd0 && torque_y_o == 32'sd0 && torque_z_o == 32'sd0))
    else $error("out of range read returned nonzero data");

endmodule

bind constraint_reaction_accumulator_top cra_checker #(.NUM_BODIES(NUM_BODIES)) u_cra_checker (.*);
